>>> sv/spf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

  localparam int COORD_W    = 24;
  localparam int RES_W      = 32;
  localparam int MAX_POINTS = 256;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SUM_W      = COORD_W + CNT_W;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int SQ_W       = PROD_W + CNT_W + 1;
  // operand width of the serial multiplier: D, Na, Nb and all sums fit
  localparam int MW         = SQ_W + CNT_W + 1;
  // accumulator and divider width: the translation numerators fit
  localparam int AW         = SUM_W + MW + 3;
  localparam int FRAC_SHIFT = 24;
  localparam int MCNT_W     = $clog2(MW);
  localparam int DCNT_W     = $clog2(AW + 3);
  localparam int PC_W       = 5;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACC, ST_ACC_END, ST_ISSUE, ST_WAIT, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    AS_MXX, AS_MYY, AS_RXMX, AS_RYMY, AS_RYMX, AS_RXMY
  } acc_step_t;

  typedef enum logic [2:0] {
    UOP_CLR, UOP_MADD, UOP_MSUB, UOP_STORE, UOP_DIV, UOP_CHECK, UOP_END
  } uop_t;

  typedef enum logic [3:0] {
    OPR_W, OPR_X1, OPR_Y1, OPR_X2, OPR_Y2, OPR_Z, OPR_C1, OPR_C2,
    OPR_D, OPR_NA, OPR_NB, OPR_WD
  } opr_t;

  typedef enum logic [1:0] {
    SLOT_COS, SLOT_SIN, SLOT_TX, SLOT_TY
  } slot_t;

  typedef struct packed {
    uop_t  op;
    opr_t  a;
    opr_t  b;
    logic  shl;
    slot_t slot;
  } uinstr_t;

  typedef struct packed {
    logic      load;
    logic      acc_vld;
    acc_step_t acc_step;
    logic      issue;
    uinstr_t   instr;
    logic      begin_solve;
    logic      set_singular;
    logic      clear_sums;
  } spf_cmd_t;

  typedef struct packed {
    logic busy;
    logic last;
    logic d_nonpos;
  } spf_stat_t;

  function automatic uinstr_t ui(input uop_t op, input opr_t a, input opr_t b,
                                 input logic shl, input slot_t slot);
    uinstr_t r;
    r.op   = op;
    r.a    = a;
    r.b    = b;
    r.shl  = shl;
    r.slot = slot;
    return r;
  endfunction

  // solve program: D, then a, b, W*D, tx, ty
  function automatic uinstr_t ucode(input logic [PC_W-1:0] pc);
    uinstr_t r;
    case (pc)
      5'd0:  r = ui(UOP_CLR,   OPR_W,  OPR_W,  1'b0, SLOT_COS);
      5'd1:  r = ui(UOP_MADD,  OPR_W,  OPR_Z,  1'b0, SLOT_COS);
      5'd2:  r = ui(UOP_MSUB,  OPR_X2, OPR_X2, 1'b0, SLOT_COS);
      5'd3:  r = ui(UOP_MSUB,  OPR_Y2, OPR_Y2, 1'b0, SLOT_COS);
      5'd4:  r = ui(UOP_STORE, OPR_D,  OPR_W,  1'b0, SLOT_COS);
      5'd5:  r = ui(UOP_CHECK, OPR_W,  OPR_W,  1'b0, SLOT_COS);
      5'd6:  r = ui(UOP_CLR,   OPR_W,  OPR_W,  1'b0, SLOT_COS);
      5'd7:  r = ui(UOP_MADD,  OPR_W,  OPR_C1, 1'b0, SLOT_COS);
      5'd8:  r = ui(UOP_MSUB,  OPR_X1, OPR_X2, 1'b0, SLOT_COS);
      5'd9:  r = ui(UOP_MSUB,  OPR_Y1, OPR_Y2, 1'b0, SLOT_COS);
      5'd10: r = ui(UOP_STORE, OPR_NA, OPR_W,  1'b0, SLOT_COS);
      5'd11: r = ui(UOP_DIV,   OPR_W,  OPR_D,  1'b1, SLOT_COS);
      5'd12: r = ui(UOP_CLR,   OPR_W,  OPR_W,  1'b0, SLOT_COS);
      5'd13: r = ui(UOP_MADD,  OPR_W,  OPR_C2, 1'b0, SLOT_COS);
      5'd14: r = ui(UOP_MADD,  OPR_X1, OPR_Y2, 1'b0, SLOT_COS);
      5'd15: r = ui(UOP_MSUB,  OPR_Y1, OPR_X2, 1'b0, SLOT_COS);
      5'd16: r = ui(UOP_STORE, OPR_NB, OPR_W,  1'b0, SLOT_COS);
      5'd17: r = ui(UOP_DIV,   OPR_W,  OPR_D,  1'b1, SLOT_SIN);
      5'd18: r = ui(UOP_CLR,   OPR_W,  OPR_W,  1'b0, SLOT_COS);
      5'd19: r = ui(UOP_MADD,  OPR_W,  OPR_D,  1'b0, SLOT_COS);
      5'd20: r = ui(UOP_STORE, OPR_WD, OPR_W,  1'b0, SLOT_COS);
      5'd21: r = ui(UOP_CLR,   OPR_W,  OPR_W,  1'b0, SLOT_COS);
      5'd22: r = ui(UOP_MADD,  OPR_X1, OPR_D,  1'b0, SLOT_COS);
      5'd23: r = ui(UOP_MSUB,  OPR_X2, OPR_NA, 1'b0, SLOT_COS);
      5'd24: r = ui(UOP_MADD,  OPR_Y2, OPR_NB, 1'b0, SLOT_COS);
      5'd25: r = ui(UOP_DIV,   OPR_W,  OPR_WD, 1'b0, SLOT_TX);
      5'd26: r = ui(UOP_CLR,   OPR_W,  OPR_W,  1'b0, SLOT_COS);
      5'd27: r = ui(UOP_MADD,  OPR_Y1, OPR_D,  1'b0, SLOT_COS);
      5'd28: r = ui(UOP_MSUB,  OPR_Y2, OPR_NA, 1'b0, SLOT_COS);
      5'd29: r = ui(UOP_MSUB,  OPR_X2, OPR_NB, 1'b0, SLOT_COS);
      5'd30: r = ui(UOP_DIV,   OPR_W,  OPR_WD, 1'b0, SLOT_TY);
      default: r = ui(UOP_END, OPR_W,  OPR_W,  1'b0, SLOT_COS);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/spf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface spf_in_if import spf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] ref_x;
  logic signed [COORD_W-1:0] ref_y;
  logic signed [COORD_W-1:0] mov_x;
  logic signed [COORD_W-1:0] mov_y;
  logic                      last_point;

  modport source (output valid, ref_x, ref_y, mov_x, mov_y, last_point, input ready);
  modport sink (input valid, ref_x, ref_y, mov_x, mov_y, last_point, output ready);
endinterface

`default_nettype wire

>>> sv/spf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface spf_out_if import spf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] scale_cos;
  logic signed [RES_W-1:0] scale_sin;
  logic signed [RES_W-1:0] shift_x;
  logic signed [RES_W-1:0] shift_y;
  logic                    singular;

  modport source (output valid, scale_cos, scale_sin, shift_x, shift_y, singular,
                  input ready);
  modport sink (input valid, scale_cos, scale_sin, shift_x, shift_y, singular,
                output ready);
endinterface

`default_nettype wire

>>> sv/similarity_procrustes_fit.sv
// each point pair: accept, six products through one 24x24 multiplier, final add
// on the last pair a solve follows: up to 16 multiplies on a bit-serial
// shift-add unit and up to 4 restoring divides
// one result is then held until taken; no pair is accepted from the last pair until then
// synchronous active-low reset clears all sums, the point count and the controller
`timescale 1ns / 1ps
`default_nettype none

module similarity_procrustes_fit import spf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  spf_in_if.sink     in_ch,
  spf_out_if.source  out_ch
);

  // command and status between sequencer and datapath
  spf_cmd_t  cmd;
  spf_stat_t stat;

  // sequencer: per-item product steps, then the solve program
  spf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: sums, accumulator, serial multiplier, divider, result registers
  spf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .ref_x      (in_ch.ref_x),
    .ref_y      (in_ch.ref_y),
    .mov_x      (in_ch.mov_x),
    .mov_y      (in_ch.mov_y),
    .last_point (in_ch.last_point),
    .scale_cos  (out_ch.scale_cos),
    .scale_sin  (out_ch.scale_sin),
    .shift_x    (out_ch.shift_x),
    .shift_y    (out_ch.shift_y),
    .singular   (out_ch.singular)
  );

endmodule

`default_nettype wire

>>> sv/spf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module spf_ctrl import spf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  spf_stat_t stat,
  output spf_cmd_t  cmd
);

  state_t           state_r, state_nxt;
  acc_step_t        step_r, step_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  uinstr_t          instr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= AS_MXX;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      pc_r    <= pc_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    pc_nxt    = pc_r;
    instr     = ucode(pc_r);
    cmd       = '0;
    cmd.instr = instr;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = AS_MXX;
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.acc_vld  = 1'b1;
        cmd.acc_step = step_r;
        if (step_r == AS_RXMY) begin
          state_nxt = ST_ACC_END;
        end else begin
          step_nxt = acc_step_t'(step_r + 3'd1);
        end
      end
      ST_ACC_END: begin
        if (stat.last) begin
          cmd.begin_solve = 1'b1;
          pc_nxt          = '0;
          state_nxt       = ST_ISSUE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ISSUE: begin
        case (instr.op)
          UOP_CHECK: begin
            if (stat.d_nonpos) begin
              cmd.set_singular = 1'b1;
              state_nxt        = ST_OUT;
            end else begin
              pc_nxt = pc_r + PC_W'(1);
            end
          end
          UOP_END: begin
            state_nxt = ST_OUT;
          end
          default: begin
            cmd.issue = 1'b1;
            state_nxt = ST_WAIT;
          end
        endcase
      end
      ST_WAIT: begin
        if (!stat.busy) begin
          pc_nxt    = pc_r + PC_W'(1);
          state_nxt = ST_ISSUE;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear_sums = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/spf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module spf_dp import spf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spf_cmd_t                  cmd,
  output spf_stat_t                 stat,
  input  logic signed [COORD_W-1:0] ref_x,
  input  logic signed [COORD_W-1:0] ref_y,
  input  logic signed [COORD_W-1:0] mov_x,
  input  logic signed [COORD_W-1:0] mov_y,
  input  logic                      last_point,
  output logic signed [RES_W-1:0]   scale_cos,
  output logic signed [RES_W-1:0]   scale_sin,
  output logic signed [RES_W-1:0]   shift_x,
  output logic signed [RES_W-1:0]   shift_y,
  output logic                      singular
);

  localparam logic [DCNT_W-1:0] DIV_NEG  = DCNT_W'(0);
  localparam logic [DCNT_W-1:0] DIV_RND  = DCNT_W'(1);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(AW + 2);

  // latched item
  logic signed [COORD_W-1:0] rx_r, ry_r, mx_r, my_r;
  logic                      last_r, take_r, last_nxt, take_nxt;

  // running sums
  logic signed [SUM_W-1:0] srx_r, sry_r, smx_r, smy_r;
  logic signed [SUM_W-1:0] srx_nxt, sry_nxt, smx_nxt, smy_nxt;
  logic signed [SQ_W-1:0]  sz_r, sc1_r, sc2_r, sz_nxt, sc1_nxt, sc2_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  // per-item product stage
  logic signed [COORD_W-1:0] pa, pb;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SQ_W-1:0]    prod_ext;
  acc_step_t                 prod_step_r;
  logic                      prod_vld_r;

  // solve registers
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [MW-1:0] d_r, na_r, nb_r, d_nxt, na_nxt, nb_nxt;
  logic [AW-1:0]        wd_r, wd_nxt;

  // serial multiplier
  logic [AW-1:0]     ma_r, ma_nxt, term;
  logic [MW-1:0]     mb_r, mb_nxt;
  logic [MCNT_W-1:0] mcnt_r, mcnt_nxt;
  logic              msub_r, msub_nxt, mbusy_r, mbusy_nxt, mlast;

  // restoring divider
  logic [AW-1:0]     dnum_r, dnum_nxt, dd_r, dd_nxt, drem_r, drem_nxt, dq_r, dq_nxt;
  logic [AW:0]       rem_sh;
  logic              dneg_r, dneg_nxt, dbusy_r, dbusy_nxt;
  slot_t             dslot_r, dslot_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [RES_W-1:0]  qsat;

  logic [RES_W-1:0] res_r [4];
  logic [RES_W-1:0] res_nxt [4];
  logic             sing_r, sing_nxt;

  function automatic logic signed [MW-1:0] opnd(input opr_t o,
      input logic [CNT_W-1:0] w, input logic signed [SUM_W-1:0] x1,
      input logic signed [SUM_W-1:0] y1, input logic signed [SUM_W-1:0] x2,
      input logic signed [SUM_W-1:0] y2, input logic signed [SQ_W-1:0] z,
      input logic signed [SQ_W-1:0] c1, input logic signed [SQ_W-1:0] c2,
      input logic signed [MW-1:0] d, input logic signed [MW-1:0] na,
      input logic signed [MW-1:0] nb);
    logic signed [MW-1:0] r;
    case (o)
      OPR_W:   r = {{(MW - CNT_W){1'b0}}, w};
      OPR_X1:  r = MW'(x1);
      OPR_Y1:  r = MW'(y1);
      OPR_X2:  r = MW'(x2);
      OPR_Y2:  r = MW'(y2);
      OPR_Z:   r = MW'(z);
      OPR_C1:  r = MW'(c1);
      OPR_C2:  r = MW'(c2);
      OPR_D:   r = d;
      OPR_NA:  r = na;
      OPR_NB:  r = nb;
      default: r = '0;
    endcase
    return r;
  endfunction

  // item capture and coordinate sums
  always_comb begin
    last_nxt = last_r;
    take_nxt = take_r;
    srx_nxt  = srx_r;
    sry_nxt  = sry_r;
    smx_nxt  = smx_r;
    smy_nxt  = smy_r;
    cnt_nxt  = cnt_r;
    if (cmd.clear_sums) begin
      srx_nxt = '0;
      sry_nxt = '0;
      smx_nxt = '0;
      smy_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.load) begin
      last_nxt = last_point;
      take_nxt = cnt_r < CNT_W'(MAX_POINTS);
      if (cnt_r < CNT_W'(MAX_POINTS)) begin
        srx_nxt = srx_r + SUM_W'(ref_x);
        sry_nxt = sry_r + SUM_W'(ref_y);
        smx_nxt = smx_r + SUM_W'(mov_x);
        smy_nxt = smy_r + SUM_W'(mov_y);
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  // one product per cycle, registered and added in the next cycle
  always_comb begin
    case (cmd.acc_step)
      AS_MXX:  begin pa = mx_r; pb = mx_r; end
      AS_MYY:  begin pa = my_r; pb = my_r; end
      AS_RXMX: begin pa = rx_r; pb = mx_r; end
      AS_RYMY: begin pa = ry_r; pb = my_r; end
      AS_RYMX: begin pa = ry_r; pb = mx_r; end
      AS_RXMY: begin pa = rx_r; pb = my_r; end
      default: begin pa = '0;   pb = '0;   end
    endcase
  end

  assign prod_ext = SQ_W'(prod_r);

  always_comb begin
    sz_nxt  = sz_r;
    sc1_nxt = sc1_r;
    sc2_nxt = sc2_r;
    if (cmd.clear_sums) begin
      sz_nxt  = '0;
      sc1_nxt = '0;
      sc2_nxt = '0;
    end else if (prod_vld_r) begin
      case (prod_step_r)
        AS_MXX, AS_MYY:   sz_nxt  = sz_r + prod_ext;
        AS_RXMX, AS_RYMY: sc1_nxt = sc1_r + prod_ext;
        AS_RYMX:          sc2_nxt = sc2_r + prod_ext;
        AS_RXMY:          sc2_nxt = sc2_r - prod_ext;
        default:          sz_nxt  = sz_r;
      endcase
    end
  end

  // apply the sign to the rounded quotient magnitude and saturate
  always_comb begin
    if (dneg_r) begin
      if ((|dq_r[AW-1:RES_W]) || (dq_r[RES_W-1] && (|dq_r[RES_W-2:0]))) begin
        qsat = {1'b1, {(RES_W - 1){1'b0}}};
      end else begin
        qsat = -dq_r[RES_W-1:0];
      end
    end else begin
      if (|dq_r[AW-1:RES_W-1]) begin
        qsat = {1'b0, {(RES_W - 1){1'b1}}};
      end else begin
        qsat = dq_r[RES_W-1:0];
      end
    end
  end

  // solve datapath: accumulator, serial multiplier, divider
  always_comb begin
    acc_nxt   = acc_r;
    d_nxt     = d_r;
    na_nxt    = na_r;
    nb_nxt    = nb_r;
    wd_nxt    = wd_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    mcnt_nxt  = mcnt_r;
    msub_nxt  = msub_r;
    mbusy_nxt = mbusy_r;
    dnum_nxt  = dnum_r;
    dd_nxt    = dd_r;
    drem_nxt  = drem_r;
    dq_nxt    = dq_r;
    dneg_nxt  = dneg_r;
    dslot_nxt = dslot_r;
    dcnt_nxt  = dcnt_r;
    dbusy_nxt = dbusy_r;
    res_nxt   = res_r;
    sing_nxt  = sing_r;
    term      = mb_r[0] ? ma_r : '0;
    mlast     = mcnt_r == MCNT_W'(MW - 1);
    rem_sh    = {drem_r, dnum_r[AW-1]};

    if (cmd.begin_solve) begin
      sing_nxt = 1'b0;
    end
    if (cmd.set_singular) begin
      sing_nxt = 1'b1;
      for (int i = 0; i < 4; i++) begin
        res_nxt[i] = '0;
      end
    end

    if (cmd.issue) begin
      case (cmd.instr.op)
        UOP_CLR: acc_nxt = '0;
        UOP_STORE: begin
          case (cmd.instr.a)
            OPR_D:   d_nxt  = acc_r[MW-1:0];
            OPR_NA:  na_nxt = acc_r[MW-1:0];
            OPR_NB:  nb_nxt = acc_r[MW-1:0];
            default: wd_nxt = acc_r;
          endcase
        end
        UOP_MADD, UOP_MSUB: begin
          ma_nxt    = AW'(opnd(cmd.instr.a, cnt_r, srx_r, sry_r, smx_r, smy_r,
                                sz_r, sc1_r, sc2_r, d_r, na_r, nb_r));
          mb_nxt    = opnd(cmd.instr.b, cnt_r, srx_r, sry_r, smx_r, smy_r,
                           sz_r, sc1_r, sc2_r, d_r, na_r, nb_r);
          mcnt_nxt  = '0;
          msub_nxt  = cmd.instr.op == UOP_MSUB;
          mbusy_nxt = 1'b1;
        end
        UOP_DIV: begin
          dnum_nxt  = cmd.instr.shl ? acc_r <<< FRAC_SHIFT : acc_r;
          dd_nxt    = (cmd.instr.b == OPR_WD) ? wd_r : AW'(d_r);
          dslot_nxt = cmd.instr.slot;
          dcnt_nxt  = '0;
          dbusy_nxt = 1'b1;
        end
        default: acc_nxt = acc_r;
      endcase
    end

    // two's complement serial multiply: top bit of b carries negative weight
    if (mbusy_r) begin
      if (msub_r ^ mlast) begin
        acc_nxt = acc_r - term;
      end else begin
        acc_nxt = acc_r + term;
      end
      ma_nxt   = ma_r << 1;
      mb_nxt   = mb_r >> 1;
      mcnt_nxt = mcnt_r + MCNT_W'(1);
      if (mlast) begin
        mbusy_nxt = 1'b0;
      end
    end

    // magnitude, add half divisor, one quotient bit a cycle, saturate
    if (dbusy_r) begin
      dcnt_nxt = dcnt_r + DCNT_W'(1);
      if (dcnt_r == DIV_NEG) begin
        dneg_nxt = dnum_r[AW-1];
        if (dnum_r[AW-1]) begin
          dnum_nxt = -dnum_r;
        end
      end else if (dcnt_r == DIV_RND) begin
        dnum_nxt = dnum_r + (dd_r >> 1);
        drem_nxt = '0;
        dq_nxt   = '0;
      end else if (dcnt_r == DIV_LAST) begin
        res_nxt[dslot_r] = qsat;
        dbusy_nxt        = 1'b0;
      end else begin
        dnum_nxt = dnum_r << 1;
        if (rem_sh >= {1'b0, dd_r}) begin
          drem_nxt = AW'(rem_sh - {1'b0, dd_r});
          dq_nxt   = {dq_r[AW-2:0], 1'b1};
        end else begin
          drem_nxt = rem_sh[AW-1:0];
          dq_nxt   = {dq_r[AW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r     <= 1'b0;
      take_r     <= 1'b0;
      srx_r      <= '0;
      sry_r      <= '0;
      smx_r      <= '0;
      smy_r      <= '0;
      sz_r       <= '0;
      sc1_r      <= '0;
      sc2_r      <= '0;
      cnt_r      <= '0;
      prod_vld_r <= 1'b0;
      mbusy_r    <= 1'b0;
      dbusy_r    <= 1'b0;
      sing_r     <= 1'b0;
    end else begin
      last_r     <= last_nxt;
      take_r     <= take_nxt;
      srx_r      <= srx_nxt;
      sry_r      <= sry_nxt;
      smx_r      <= smx_nxt;
      smy_r      <= smy_nxt;
      sz_r       <= sz_nxt;
      sc1_r      <= sc1_nxt;
      sc2_r      <= sc2_nxt;
      cnt_r      <= cnt_nxt;
      prod_vld_r <= cmd.acc_vld & take_r;
      mbusy_r    <= mbusy_nxt;
      dbusy_r    <= dbusy_nxt;
      sing_r     <= sing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rx_r <= ref_x;
      ry_r <= ref_y;
      mx_r <= mov_x;
      my_r <= mov_y;
    end
    prod_r      <= pa * pb;
    prod_step_r <= cmd.acc_step;
    acc_r       <= acc_nxt;
    d_r         <= d_nxt;
    na_r        <= na_nxt;
    nb_r        <= nb_nxt;
    wd_r        <= wd_nxt;
    ma_r        <= ma_nxt;
    mb_r        <= mb_nxt;
    mcnt_r      <= mcnt_nxt;
    msub_r      <= msub_nxt;
    dnum_r      <= dnum_nxt;
    dd_r        <= dd_nxt;
    drem_r      <= drem_nxt;
    dq_r        <= dq_nxt;
    dneg_r      <= dneg_nxt;
    dslot_r     <= dslot_nxt;
    dcnt_r      <= dcnt_nxt;
    res_r       <= res_nxt;
  end

  assign stat.busy     = mbusy_r | dbusy_r;
  assign stat.last     = last_r;
  assign stat.d_nonpos = d_r[MW-1] | (d_r == '0);

  assign scale_cos = res_r[SLOT_COS];
  assign scale_sin = res_r[SLOT_SIN];
  assign shift_x   = res_r[SLOT_TX];
  assign shift_y   = res_r[SLOT_TY];
  assign singular  = sing_r;

endmodule

`default_nettype wire
